/* hw/rtl/sks_pkg.sv */
// shared types and defaults for the stable key/tag sorter
package sks_pkg;

   localparam int MAX_ITEMS_DEFAULT = 64;
   localparam int KEY_WIDTH_DEFAULT = 32;
   localparam int KEY_FIELD_WIDTH   = 32;
   localparam int TAG_WIDTH         = 6;

   typedef struct packed {
      logic signed [KEY_FIELD_WIDTH-1:0] in_key;
      logic [TAG_WIDTH-1:0]              in_tag;
      logic                              in_last;
   } req_type;

   typedef struct packed {
      logic signed [KEY_FIELD_WIDTH-1:0] out_key;
      logic [TAG_WIDTH-1:0]              out_tag;
      logic                              out_last;
   } rsp_type;

   // per-cycle command to every cell of the chain
   typedef struct packed {
      logic load;    // insert the broadcast item
      logic shift;   // move every entry one cell toward the head
   } ctl_type;

endpackage

/* hw/rtl/sks_cell.sv */
// one cell of the insertion chain: holds a single key/tag entry
module sks_cell #(
   parameter int KEY_WIDTH = sks_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sks_pkg::ctl_type             ctl,
   input  logic [KEY_WIDTH-1:0]         new_key,
   input  logic [sks_pkg::TAG_WIDTH-1:0] new_tag,
   input  logic                         prev_ins,
   input  logic                         prev_valid,
   input  logic [KEY_WIDTH-1:0]         prev_key,
   input  logic [sks_pkg::TAG_WIDTH-1:0] prev_tag,
   input  logic                         next_valid,
   input  logic [KEY_WIDTH-1:0]         next_key,
   input  logic [sks_pkg::TAG_WIDTH-1:0] next_tag,
   output logic                         valid,
   output logic [KEY_WIDTH-1:0]         key,
   output logic [sks_pkg::TAG_WIDTH-1:0] tag,
   output logic                         ins
);

   logic                          valid_ff, valid_in;
   logic [KEY_WIDTH-1:0]          key_ff, key_in;
   logic [sks_pkg::TAG_WIDTH-1:0] tag_ff, tag_in;

   // strict compare keeps equal keys in arrival order
   assign ins = !valid_ff || ($signed(new_key) < $signed(key_ff));

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      tag_in   = tag_ff;
      if (ctl.shift) begin
         valid_in = next_valid;
         key_in   = next_key;
         tag_in   = next_tag;
      end else if (ctl.load && ins) begin
         if (prev_ins) begin
            valid_in = prev_valid;
            key_in   = prev_key;
            tag_in   = prev_tag;
         end else begin
            valid_in = 1'b1;
            key_in   = new_key;
            tag_in   = new_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign valid = valid_ff;
   assign key   = key_ff;
   assign tag   = tag_ff;

endmodule

/* hw/rtl/sks_ctrl.sv */
// load/drain sequencer, item count and result register
module sks_ctrl #(
   parameter int MAX_ITEMS = sks_pkg::MAX_ITEMS_DEFAULT,
   parameter int KEY_WIDTH = sks_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_last,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sks_pkg::rsp_type              rsp_data,
   input  logic                          head_valid,
   input  logic [KEY_WIDTH-1:0]          head_key,
   input  logic [sks_pkg::TAG_WIDTH-1:0] head_tag,
   output sks_pkg::ctl_type              ctl
);

   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   localparam logic ST_LOAD  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic             state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sks_pkg::rsp_type rsp_ff, rsp_in;
   logic             accept, fire;

   assign req_stall = (state_ff == ST_DRAIN);
   assign accept    = req_valid && !req_stall;
   assign fire      = (state_ff == ST_DRAIN) && (!rsp_valid_ff || !rsp_stall);

   assign ctl.load  = accept;
   assign ctl.shift = fire;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cnt_in = cnt_ff + CNT_ONE;
               if (req_last || (cnt_in == CNT_MAX)) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (fire) begin
               rsp_valid_in     = 1'b1;
               rsp_in.out_key   = sks_pkg::KEY_FIELD_WIDTH'(head_key);
               rsp_in.out_tag   = head_tag;
               rsp_in.out_last  = (cnt_ff == CNT_ONE);
               cnt_in           = cnt_ff - CNT_ONE;
               if (cnt_ff == CNT_ONE) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> cnt_ff != '0)
      else $error("drain with empty count");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ctl.load && ctl.shift))
      else $error("load and shift in the same cycle");

   a_head_present: assert property (@(posedge clock) disable iff (reset)
      ctl.shift |-> head_valid)
      else $error("drain read an empty head cell");

   a_final_beat: assert property (@(posedge clock) disable iff (reset)
      fire && cnt_ff == CNT_ONE |=> state_ff == ST_LOAD && cnt_ff == '0 && rsp_data.out_last)
      else $error("final beat did not close the set");

   a_close_on_full: assert property (@(posedge clock) disable iff (reset)
      accept && cnt_ff == CNT_MAX - CNT_ONE |=> state_ff == ST_DRAIN)
      else $error("full store did not close the set");

endmodule

/* hw/rtl/stable_key_tag_sorter.sv */
// top level of the stable key/tag sorter: cell chain plus sequencer
//
// usage
// - req channel (req_valid/req_stall/req_data) takes one item per beat: a
//   signed key, a 6-bit tag and a last flag; the chain inserts each item in
//   sorted position in the cycle it is accepted, so loading runs at one beat
//   per cycle
// - a set closes on a beat with in_last set, or on the beat that fills the
//   chain to MAX_ITEMS entries
// - after closing, req_stall stays high while the set drains from the head
//   cell onto the rsp channel, ascending by key, equal keys in arrival order,
//   out_last on the final beat
// - a set loads in full before it drains; after the closing beat the state
//   register switches to drain, then the rsp register takes the head entry
// - rsp is a registered output: while rsp_stall is high and a beat waits, the
//   chain holds and the waiting beat stays put; the next set may load while
//   the final beat still waits
// - reset empties the chain and the count; key/tag contents are not cleared
// - keys keep their low KEY_WIDTH bits, compared as two's complement
module stable_key_tag_sorter #(
   parameter int MAX_ITEMS = sks_pkg::MAX_ITEMS_DEFAULT,
   parameter int KEY_WIDTH = sks_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sks_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sks_pkg::rsp_type rsp_data
);

   sks_pkg::ctl_type              ctl;
   logic [KEY_WIDTH-1:0]          new_key;

   // per-cell entry taps, read by the neighbors and, for the head, by the sequencer
   logic                          c_valid [MAX_ITEMS];
   logic [KEY_WIDTH-1:0]          c_key   [MAX_ITEMS];
   logic [sks_pkg::TAG_WIDTH-1:0] c_tag   [MAX_ITEMS];
   logic                          c_ins   [MAX_ITEMS];

   // keep the low key bits, zero-fill above the 32-bit field
   assign new_key = KEY_WIDTH'($unsigned(req_data.in_key));

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic                          p_ins, p_valid, n_valid;
      logic [KEY_WIDTH-1:0]          p_key, n_key;
      logic [sks_pkg::TAG_WIDTH-1:0] p_tag, n_tag;

      if (i == 0) begin : g_head
         // head cell always takes a fresh item when it inserts
         assign p_ins   = 1'b0;
         assign p_valid = 1'b0;
         assign p_key   = '0;
         assign p_tag   = '0;
      end else begin : g_body
         assign p_ins   = c_ins[i-1];
         assign p_valid = c_valid[i-1];
         assign p_key   = c_key[i-1];
         assign p_tag   = c_tag[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
         // empty entry flows in behind the drain
         assign n_valid = 1'b0;
         assign n_key   = '0;
         assign n_tag   = '0;
      end else begin : g_inner
         assign n_valid = c_valid[i+1];
         assign n_key   = c_key[i+1];
         assign n_tag   = c_tag[i+1];
      end

      sks_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_key    (new_key),
         .new_tag    (req_data.in_tag),
         .prev_ins   (p_ins),
         .prev_valid (p_valid),
         .prev_key   (p_key),
         .prev_tag   (p_tag),
         .next_valid (n_valid),
         .next_key   (n_key),
         .next_tag   (n_tag),
         .valid      (c_valid[i]),
         .key        (c_key[i]),
         .tag        (c_tag[i]),
         .ins        (c_ins[i])
      );
   end

   // sequencer: load/drain mode, item count, output beat register
   sks_ctrl #(
      .MAX_ITEMS (MAX_ITEMS),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_last   (req_data.in_last),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .head_valid (c_valid[0]),
      .head_key   (c_key[0]),
      .head_tag   (c_tag[0]),
      .ctl        (ctl)
   );

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the stable key/tag sorter with a queue-fed driver and a beat monitor
module tb_top;
   import sks_pkg::*;

   localparam int CLOCK_PERIOD = 4;
   localparam int RESET_CYCLES = 5;
   localparam int MAX_SET      = MAX_ITEMS_DEFAULT;
   localparam int RANDOM_ITEMS = 400;
   localparam int SHORT_SET    = 12;       // most random sets stay short
   localparam int HOLD_CYCLES  = 300;      // long sink hold-off, forces the chain to back up
   localparam int GUARD_CYCLES = 20;       // quiet time after the last beat owed
   localparam int REPORT_LIMIT = 10;
   localparam int LIMIT_CYCLES = 200000;
   localparam int SLOW_PCT     = 56;
   localparam int LIGHT_PCT    = 19;

   localparam logic signed [KEY_FIELD_WIDTH-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_FIELD_WIDTH-1:0] KEY_MAX = 32'sh7fff_ffff;

   // traffic phases: slow sink first, then slow source, then free running
   typedef enum logic [1:0] {
      PACE_SLOW_SINK,
      PACE_SLOW_SOURCE,
      PACE_OPEN
   } pace_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // stimulus waiting to be driven
   req_type stim_queue[$];
   int      stim_total = 0;

   // items of the set still open, in arrival order
   logic signed [KEY_FIELD_WIDTH-1:0] set_keys[$];
   logic [TAG_WIDTH-1:0]              set_tags[$];

   // sorted beats the block still owes us, oldest first
   rsp_type sorted_due[$];

   logic     req_taken  = 1'b0;
   int       beats_in   = 0;
   int       mismatches = 0;
   int       hold_left  = 0;
   bit       hold_done  = 1'b0;
   pace_type pace;

   assign pace = (3 * beats_in < stim_total)     ? PACE_SLOW_SINK   :
                 (3 * beats_in < 2 * stim_total) ? PACE_SLOW_SOURCE : PACE_OPEN;

   stable_key_tag_sorter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // expected results
   // ---------------------------------------------------------------

   // stable insertion sort of the open set, then queue one beat per item
   function automatic void sort_open_set();
      logic signed [KEY_FIELD_WIDTH-1:0] k;
      logic [TAG_WIDTH-1:0]              t;
      int                                j;
      rsp_type                           beat;
      for (int i = 1; i < set_keys.size(); i++) begin
         k = set_keys[i];
         t = set_tags[i];
         j = i;
         // walk left only past strictly larger keys, ties keep arrival order
         while (j > 0 && set_keys[j - 1] > k) begin
            set_keys[j] = set_keys[j - 1];
            set_tags[j] = set_tags[j - 1];
            j--;
         end
         set_keys[j] = k;
         set_tags[j] = t;
      end
      foreach (set_keys[i]) begin
         beat.out_key  = set_keys[i];
         beat.out_tag  = set_tags[i];
         beat.out_last = (i == set_keys.size() - 1);
         sorted_due.push_back(beat);
      end
      set_keys.delete();
      set_tags.delete();
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%0t: %s, got key %0d tag %0d last %0b", $time, what,
                  rsp_data.out_key, rsp_data.out_tag, rsp_data.out_last);
      end
   endtask

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   function automatic void add_item(input logic signed [KEY_FIELD_WIDTH-1:0] key,
                                    input int tag, input bit last);
      req_type item;
      item.in_key  = key;
      item.in_tag  = TAG_WIDTH'(tag);
      item.in_last = last;
      stim_queue.push_back(item);
   endfunction

   function automatic logic signed [KEY_FIELD_WIDTH-1:0] random_key();
      case ($urandom_range(9))
         0: return KEY_MIN;
         1: return KEY_MAX;
         // crowded range around zero gives plenty of ties
         2, 3, 4: return $urandom_range(6) - 3;
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // driver: new beat at the falling edge once the old one is taken
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (stim_queue.size() != 0 &&
             $urandom_range(99) >= (pace == PACE_SLOW_SINK   ? LIGHT_PCT :
                                    pace == PACE_SLOW_SOURCE ? SLOW_PCT  : 0)) begin
            req_valid <= 1'b1;
            req_data  <= stim_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // one long sink hold-off once the open phase starts, sender keeps pushing
   always @(negedge clock) begin
      if (!hold_done && pace == PACE_OPEN && beats_in > 0) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // sink side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_left > 0 ||
                      $urandom_range(99) < (pace == PACE_SLOW_SINK   ? SLOW_PCT  :
                                            pace == PACE_SLOW_SOURCE ? LIGHT_PCT : 0);
      end
   end

   // ---------------------------------------------------------------
   // monitor: both channels sampled at the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin : sample_ports
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            beats_in <= beats_in + 1;
            set_keys.push_back(req_data.in_key);
            set_tags.push_back(req_data.in_tag);
            // a set closes on the last flag or when the store fills
            if (req_data.in_last || set_keys.size() == MAX_SET) begin
               sort_open_set();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (sorted_due.size() == 0) begin
               note_mismatch("beat with nothing expected");
            end else begin
               want = sorted_due.pop_front();
               if (rsp_data.out_key !== want.out_key || rsp_data.out_tag !== want.out_tag ||
                   rsp_data.out_last !== want.out_last) begin
                  note_mismatch($sformatf("expected key %0d tag %0d last %0b",
                                          want.out_key, want.out_tag, want.out_last));
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------
   initial begin : stimulus
      int left;
      int len;
      int sets;
      bit close_full;
      // single-item sets at both key extremes and both tag extremes
      add_item(KEY_MIN, 0, 1'b1);
      add_item(KEY_MAX, 63, 1'b1);
      // mixed set with repeated keys to check stable order
      add_item(5, 1, 1'b0);
      add_item(-1, 2, 1'b0);
      add_item(32'shaaaa_aaaa, 42, 1'b0);
      add_item(5, 3, 1'b0);
      add_item(KEY_MAX, 4, 1'b0);
      add_item(32'sh5555_5555, 21, 1'b0);
      add_item(-1, 5, 1'b0);
      add_item(5, 6, 1'b0);
      add_item(KEY_MIN, 7, 1'b1);
      // tie on the most negative key, high tag arrives first
      add_item(KEY_MIN, 63, 1'b0);
      add_item(KEY_MIN, 0, 1'b1);
      // fully descending run
      add_item(3, 10, 1'b0);
      add_item(2, 11, 1'b0);
      add_item(1, 12, 1'b0);
      add_item(0, 13, 1'b0);
      add_item(-1, 14, 1'b0);
      add_item(-2, 15, 1'b1);

      // random sets, now and then a full store; set 2 closes only by filling,
      // set 6 carries the last flag on the filling item
      left = RANDOM_ITEMS;
      sets = 0;
      while (left > 0) begin
         if (sets == 2 || sets == 6 || $urandom_range(14) == 0) begin
            len = MAX_SET;
         end else begin
            len = $urandom_range(1, SHORT_SET);
         end
         close_full = (sets == 6) || (sets != 2 && $urandom_range(1) == 1);
         for (int i = 0; i < len; i++) begin
            add_item(random_key(), $urandom_range(63),
                     i == len - 1 && (len < MAX_SET || close_full));
         end
         left -= len;
         sets++;
      end
      stim_total = stim_queue.size();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all items taken, all sorted beats back, then a quiet stretch
      while (stim_queue.size() != 0 || req_valid) @(posedge clock);
      while (sorted_due.size() != 0) @(posedge clock);
      repeat (GUARD_CYCLES) @(posedge clock);

      if (mismatches == 0 && sorted_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/sks_pkg.sv
hw/rtl/sks_cell.sv
hw/rtl/sks_ctrl.sv
hw/rtl/stable_key_tag_sorter.sv
tb/tb_top.sv
